// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL of the word tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QWT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion label failed");

// Condition that must never be true outside reset.
`define QWT_ASSERT_NEVER(label, clk, rstn, expr) \
    `QWT_ASSERT(label, clk, rstn, !(expr))

`endif

// ----- hw/rtl/qwt_pkg.sv -----
// Package with the word tokenizer's types, codes and sizes.
`default_nettype none

package qwt_pkg;

    // Line and count sizes.
    localparam int MAX_LINE   = 4096;
    localparam int MAX_TOKENS = 256;
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int LEN_W      = POS_W + 1;
    localparam int CNT_W      = $clog2(MAX_TOKENS) + 1;

    // Result queue size; a word can push two results at once.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = PTR_W + 1;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Result kinds.
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One input word.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_line;
    } qwt_in_t;

    // One result word.
    typedef struct packed {
        logic [1:0]       kind;
        logic [POS_W-1:0] start_offset;
        logic [LEN_W-1:0] token_length;
        logic [CNT_W-1:0] token_total;
        logic [POS_W-1:0] error_offset;
        logic             last_of_run;
    } qwt_out_t;

    // Push request from the scanner to the result queue.
    typedef struct packed {
        logic push0;
        logic push1;
    } qwt_push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qwt_scan.sv -----
// Scanner: tokenizer state and the results caused by one character.
`default_nettype none

module qwt_scan (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire qwt_pkg::qwt_in_t in_word,
    output qwt_pkg::qwt_push_t    push,
    output qwt_pkg::qwt_out_t     rec0,
    output qwt_pkg::qwt_out_t     rec1
);

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_QUOTE   = 2'd2
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic [qwt_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [qwt_pkg::POS_W-1:0]      start_reg, start_next;
    logic [qwt_pkg::POS_W-1:0]      nonblank_reg, nonblank_next;
    logic [qwt_pkg::POS_W-1:0]      qopen_reg, qopen_next;
    logic                           seen_reg, seen_next;
    logic [qwt_pkg::CNT_W-1:0]      count_reg, count_next;

    logic                           is_space, is_quote, is_blank, eol;
    logic                           tok_hit;
    logic [qwt_pkg::POS_W-1:0]      tok_start;
    logic [qwt_pkg::LEN_W-1:0]      tok_len;
    logic [qwt_pkg::POS_W-1:0]      err_at;
    qwt_pkg::qwt_out_t              tok_rec, fin_rec;

    // Classify the character.
    assign is_space = (in_word.char_code == qwt_pkg::CH_SPACE);
    assign is_quote = (in_word.char_code == qwt_pkg::CH_QUOTE);
    assign is_blank = is_space || (in_word.char_code == qwt_pkg::CH_TAB)
                      || (in_word.char_code == qwt_pkg::CH_NL);
    assign eol      = in_word.end_of_line;

    // Next state and the token, if any, that this character closes.
    always_comb begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        nonblank_next = nonblank_reg;
        qopen_next    = qopen_reg;
        seen_next     = seen_reg;
        tok_hit       = 1'b0;
        tok_start     = '0;
        tok_len       = '0;

        unique case (mode_reg)
            MODE_WORD: begin
                if (is_space || is_quote) begin
                    tok_hit   = 1'b1;
                    tok_start = start_reg;
                    tok_len   = {1'b0, pos_reg - start_reg};
                    mode_next = MODE_BETWEEN;
                    if (is_quote) begin
                        mode_next  = MODE_QUOTE;
                        qopen_next = pos_reg;
                        seen_next  = 1'b0;
                    end
                end
            end
            MODE_QUOTE: begin
                if (is_quote) begin
                    // Empty quotes give no token.
                    if (pos_reg != qopen_reg + qwt_pkg::POS_W'(1)) begin
                        tok_hit = 1'b1;
                        if (seen_reg) begin
                            tok_start = start_reg;
                            tok_len   = {1'b0, nonblank_reg - start_reg}
                                        + qwt_pkg::LEN_W'(1);
                        end else begin
                            // Blank-only quotes: empty token at the closing quote.
                            tok_start = pos_reg;
                        end
                    end
                    mode_next = MODE_BETWEEN;
                end else if (!is_blank) begin
                    if (!seen_reg) begin
                        start_next = pos_reg;
                        seen_next  = 1'b1;
                    end
                    nonblank_next = pos_reg;
                end
            end
            default: begin
                mode_next = MODE_BETWEEN;
                if (is_quote) begin
                    mode_next  = MODE_QUOTE;
                    qopen_next = pos_reg;
                    seen_next  = 1'b0;
                end else if (!is_space) begin
                    mode_next  = MODE_WORD;
                    start_next = pos_reg;
                end
            end
        endcase

        // A word still open at the end of the line is closed here.
        if (eol && mode_next == MODE_WORD) begin
            tok_hit   = 1'b1;
            tok_start = start_next;
            tok_len   = {1'b0, pos_reg - start_next} + qwt_pkg::LEN_W'(1);
        end

        // The count saturates at the token limit.
        count_next = count_reg;
        if (tok_hit && count_reg < qwt_pkg::CNT_W'(qwt_pkg::MAX_TOKENS)) begin
            count_next = count_reg + qwt_pkg::CNT_W'(1);
        end

        err_at   = qopen_next;
        pos_next = pos_reg + qwt_pkg::POS_W'(1);

        // The line ends: everything returns to its reset values.
        if (eol) begin
            mode_next     = MODE_BETWEEN;
            pos_next      = '0;
            start_next    = '0;
            nonblank_next = '0;
            qopen_next    = '0;
            seen_next     = 1'b0;
        end
    end

    // Build the token record and the closing record.
    always_comb begin
        tok_rec              = '0;
        tok_rec.kind         = qwt_pkg::KIND_TOKEN;
        tok_rec.start_offset = tok_start;
        tok_rec.token_length = tok_len;
        tok_rec.token_total  = count_next;
        tok_rec.last_of_run  = !eol;

        fin_rec             = '0;
        fin_rec.kind        = qwt_pkg::KIND_DONE;
        fin_rec.token_total = count_next;
        fin_rec.last_of_run = 1'b1;
        // A quote still open after this character gives the error record.
        if ((mode_reg == MODE_QUOTE) != is_quote) begin
            fin_rec.kind         = qwt_pkg::KIND_ERROR;
            fin_rec.error_offset = err_at;
        end
    end

    // Results: an optional token followed by the closing record at line end.
    always_comb begin
        push.push0 = 1'b0;
        push.push1 = 1'b0;
        rec0       = tok_rec;
        rec1       = fin_rec;
        if (step) begin
            push.push0 = tok_hit || eol;
            push.push1 = tok_hit && eol;
        end
        if (!tok_hit) begin
            rec0 = fin_rec;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_BETWEEN;
            pos_reg      <= '0;
            start_reg    <= '0;
            nonblank_reg <= '0;
            qopen_reg    <= '0;
            seen_reg     <= 1'b0;
            count_reg    <= '0;
        end else if (step) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            nonblank_reg <= nonblank_next;
            qopen_reg    <= qopen_next;
            seen_reg     <= seen_next;
            count_reg    <= eol ? '0 : count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/qwt_out_fifo.sv -----
// Result queue: takes up to two words a cycle and hands out one.
`default_nettype none

module qwt_out_fifo (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire qwt_pkg::qwt_push_t         push,
    input  wire qwt_pkg::qwt_out_t          wr0,
    input  wire qwt_pkg::qwt_out_t          wr1,
    input  wire logic                       pop,
    output qwt_pkg::qwt_out_t               rd_data,
    output logic                            rd_valid,
    output logic [qwt_pkg::LVL_W-1:0]       level
);

    qwt_pkg::qwt_out_t               mem [qwt_pkg::FIFO_DEPTH];
    logic [qwt_pkg::PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [qwt_pkg::LVL_W-1:0]       level_reg, level_next;
    logic                            do_pop;

    assign rd_valid = (level_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign level    = level_reg;
    assign do_pop   = pop && rd_valid;

    // Fill level after this cycle's pushes and pop.
    always_comb begin
        level_next = level_reg + qwt_pkg::LVL_W'(push.push0)
                     + qwt_pkg::LVL_W'(push.push1) - qwt_pkg::LVL_W'(do_pop);
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (push.push1) begin
            mem[wr_ptr_reg + qwt_pkg::PTR_W'(1)] <= wr1;
        end
    end

    // Pointers and level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + qwt_pkg::PTR_W'(push.push0)
                          + qwt_pkg::PTR_W'(push.push1);
            rd_ptr_reg <= rd_ptr_reg + qwt_pkg::PTR_W'(do_pop);
            level_reg  <= level_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/quoted_word_tokenizer_top.sv -----
// A word accepted into the input register is scanned from there, and its results are
// written into the result queue behind the scanner, from which m_data is read.
// Throughput: one character per cycle while the result queue has room for two results;
// a line end that closes a word gives two results, absorbed by the four-entry queue.
// Reset: aresetn is synchronous and active low; it clears the scan state, the
// token count and the queue; s_ready is low during reset and words are taken after it.
`default_nettype none

`include "assert_macros.svh"

module quoted_word_tokenizer_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire qwt_pkg::qwt_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qwt_pkg::qwt_out_t      m_data
);

    qwt_pkg::qwt_in_t                in_reg;
    logic                            in_valid_reg;
    logic                            room;
    logic                            advance;
    logic                            s_take;
    logic [qwt_pkg::LVL_W-1:0]       level;
    qwt_pkg::qwt_push_t              push;
    qwt_pkg::qwt_out_t               rec0, rec1;

    // The scanner steps when the queue has space for two results.
    assign room    = (level <= qwt_pkg::LVL_W'(qwt_pkg::FIFO_DEPTH - 2));
    assign advance = in_valid_reg && room;
    assign s_ready = aresetn && (!in_valid_reg || room);
    assign s_take  = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
    end

    qwt_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_word (in_reg),
        .push    (push),
        .rec0    (rec0),
        .rec1    (rec1)
    );

    qwt_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr0      (rec0),
        .wr1      (rec1),
        .pop      (m_ready),
        .rd_data  (m_data),
        .rd_valid (m_valid),
        .level    (level)
    );

    // The queue never overfills.
    `QWT_ASSERT(a_level_bound, aclk, aresetn,
        level <= qwt_pkg::LVL_W'(qwt_pkg::FIFO_DEPTH))
    // Done and error records always close the run of one character.
    `QWT_ASSERT(a_final_last, aclk, aresetn,
        (m_valid && m_data.kind != qwt_pkg::KIND_TOKEN) |-> m_data.last_of_run)
    // A token record always counts at least that token.
    `QWT_ASSERT_NEVER(a_token_count, aclk, aresetn,
        m_valid && m_data.kind == qwt_pkg::KIND_TOKEN && m_data.token_total == '0)

endmodule

`default_nettype wire
